// ----- hdl/assert_macros.svh -----
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SVG_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("assertion failed");
`define SVG_ASSERT_NORST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define SVG_ASSERT(lbl, clk, rstn, prop)
`define SVG_ASSERT_NORST(lbl, clk, prop)
`endif
`endif

// ----- hdl/svg_pkg.sv -----
// ---------------------------------------------------------------------------
// svg_pkg: shared types and constants of the star vertex generator
// holds the command struct between front and back and the cordic table
// ---------------------------------------------------------------------------
package svg_pkg;

  localparam int unsigned CordicIters = 24;

  // one vertex job handed from front to back
  typedef struct packed {
    logic [5:0]         sides;
    logic signed [23:0] center_x;
    logic signed [23:0] center_y;
    logic [23:0]        radius;
    logic [15:0]        angle;
    logic               is_outer;
    logic [5:0]         vertex_number;
    logic               path_start;
    logic               path_end;
  } vtx_cmd_t;

  typedef enum logic [1:0] {
    FrIdle,
    FrDivide,
    FrEmit
  } fr_state_e;

  // back engine phases
  typedef enum logic [2:0] {
    BkIdle,
    BkCordic,
    BkMul,
    BkPlace,
    BkOut
  } bk_state_e;

  // arctangent table in 2^-32 turns
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    begin
      case (i)
        5'd0:  r = 32'h20000000;
        5'd1:  r = 32'h12E4051E;
        5'd2:  r = 32'h09FB385B;
        5'd3:  r = 32'h051111D4;
        5'd4:  r = 32'h028B0D43;
        5'd5:  r = 32'h0145D7E1;
        5'd6:  r = 32'h00A2F61E;
        5'd7:  r = 32'h00517C55;
        5'd8:  r = 32'h0028BE53;
        5'd9:  r = 32'h00145F2F;
        5'd10: r = 32'h000A2F98;
        5'd11: r = 32'h000517CC;
        5'd12: r = 32'h00028BE6;
        5'd13: r = 32'h000145F3;
        5'd14: r = 32'h0000A2FA;
        5'd15: r = 32'h0000517D;
        5'd16: r = 32'h000028BE;
        5'd17: r = 32'h0000145F;
        5'd18: r = 32'h00000A30;
        5'd19: r = 32'h00000518;
        5'd20: r = 32'h0000028C;
        5'd21: r = 32'h00000146;
        5'd22: r = 32'h000000A3;
        5'd23: r = 32'h00000051;
        default: r = 32'h0;
      endcase
      return r;
    end
  endfunction

endpackage

// ----- hdl/star_vertex_generator_core.sv -----
// vertices are computed by the 24-step serial cordic in the back engine,
// which works on one vertex job at a time
// stars with a zero radius or fewer than 3 sides are accepted and dropped
// with no vertex issued
// reset: asynchronous active low, clears both state machines, the output valid and the queue
// ---------------------------------------------------------------------------
// star_vertex_generator_core: star polygon vertex generator
// front sequencer, job queue and cordic back engine
// ---------------------------------------------------------------------------
module star_vertex_generator_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // side_count[5:0] center_x[29:6] center_y[53:30] outer_radius[77:54]
  // inner_radius[101:78] outer_angle[117:102] inner_angle[133:118]
  input  logic [135:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // point_x[25:0] point_y[51:26] vertex_number[57:52]
  output logic [63:0] m_axis_tdata,
  // is_outer[0] path_start[1]
  output logic [1:0]  m_axis_tuser,
  // path_end
  output logic        m_axis_tlast
);
  import svg_pkg::*;

  vtx_cmd_t   fq_cmd, qb_cmd;
  logic       fq_valid, fq_ready, qb_valid, qb_ready;
  logic [25:0] px, py;
  logic [5:0]  vn;

  svg_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .side_count_i(s_axis_tdata[5:0]), .center_x_i(s_axis_tdata[29:6]),
    .center_y_i(s_axis_tdata[53:30]), .outer_radius_i(s_axis_tdata[77:54]),
    .inner_radius_i(s_axis_tdata[101:78]), .outer_angle_i(s_axis_tdata[117:102]),
    .inner_angle_i(s_axis_tdata[133:118]),
    .cmd_valid_o(fq_valid), .cmd_ready_i(fq_ready), .cmd_o(fq_cmd)
  );

  svg_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(fq_valid), .wr_ready_o(fq_ready), .wr_data_i(fq_cmd),
    .rd_valid_o(qb_valid), .rd_ready_i(qb_ready), .rd_data_o(qb_cmd)
  );

  svg_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(qb_valid), .cmd_ready_o(qb_ready), .cmd_i(qb_cmd),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .point_x_o(px), .point_y_o(py), .is_outer_o(m_axis_tuser[0]),
    .vertex_number_o(vn), .path_start_o(m_axis_tuser[1]),
    .path_end_o(m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, vn, py, px};
endmodule

// ----- hdl/svg_front.sv -----
// ---------------------------------------------------------------------------
// svg_front: star intake and vertex job sequencer
// checks each star, works out angle steps by a serial divider and issues
// one job per vertex in path order
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module svg_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [5:0]        side_count_i,
  input  logic [23:0]       center_x_i,
  input  logic [23:0]       center_y_i,
  input  logic [23:0]       outer_radius_i,
  input  logic [23:0]       inner_radius_i,
  input  logic [15:0]       outer_angle_i,
  input  logic [15:0]       inner_angle_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output svg_pkg::vtx_cmd_t cmd_o
);
  import svg_pkg::*;

  fr_state_e   state_q, state_d;
  logic [5:0]  sides_q;
  logic [23:0] cx_q, cy_q, r1_q, r2_q;
  logic [15:0] a1_q, a2_q;
  logic [4:0]  k_q;
  logic        pass_q;
  // serial divider: numerator k*2^16 + sides/2, 22 bits
  logic [21:0] num_q;
  logic [5:0]  rem_q;
  logic [21:0] quo_q;
  logic [4:0]  bit_q;
  logic [15:0] off_q;

  logic [5:0]  sides_sat;
  logic        skip;
  logic [6:0]  trial;
  logic        last_vtx;

  assign sides_sat = (side_count_i > 6'd32) ? 6'd32 : side_count_i;
  assign skip = (outer_radius_i == 24'd0) || (inner_radius_i == 24'd0) ||
                (side_count_i < 6'd3);
  assign trial = {rem_q, num_q[bit_q]};
  assign last_vtx = pass_q && ({1'b0, k_q} == sides_q - 6'd1);

  // next state
  always_comb begin
    state_d = state_q;
    in_ready_o = 1'b0;
    cmd_valid_o = 1'b0;
    unique case (state_q)
      FrIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i && !skip) state_d = FrDivide;
      end
      FrDivide: begin
        if (bit_q == 5'd0) state_d = FrEmit;
      end
      FrEmit: begin
        cmd_valid_o = 1'b1;
        if (cmd_ready_i && pass_q) begin
          state_d = last_vtx ? FrIdle : FrDivide;
        end
      end
      default: state_d = FrIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FrIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      FrIdle: begin
        sides_q <= sides_sat;
        cx_q <= center_x_i;
        cy_q <= center_y_i;
        r1_q <= outer_radius_i;
        r2_q <= inner_radius_i;
        a1_q <= outer_angle_i;
        a2_q <= inner_angle_i;
        k_q <= 5'd0;
        pass_q <= 1'b0;
        num_q <= {16'd0, 1'b0, sides_sat[5:1]};
        rem_q <= 6'd0;
        bit_q <= 5'd21;
      end
      FrDivide: begin
        if (trial >= {1'b0, sides_q}) begin
          rem_q <= 6'(trial - {1'b0, sides_q});
          quo_q[bit_q] <= 1'b1;
        end else begin
          rem_q <= trial[5:0];
          quo_q[bit_q] <= 1'b0;
        end
        if (bit_q == 5'd0) begin
          off_q <= (bit_q == 5'd0 && trial >= {1'b0, sides_q}) ?
                   {quo_q[15:1], 1'b1} : {quo_q[15:1], 1'b0};
        end else begin
          bit_q <= bit_q - 5'd1;
        end
      end
      FrEmit: begin
        if (cmd_ready_i) begin
          pass_q <= ~pass_q;
          if (pass_q) begin
            k_q <= k_q + 5'd1;
            num_q <= {k_q + 5'd1, 16'd0} + {16'd0, 1'b0, sides_q[5:1]};
            rem_q <= 6'd0;
            bit_q <= 5'd21;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    cmd_o.sides = sides_q;
    cmd_o.center_x = cx_q;
    cmd_o.center_y = cy_q;
    cmd_o.radius = pass_q ? r2_q : r1_q;
    cmd_o.angle = (pass_q ? a2_q : a1_q) + off_q;
    cmd_o.is_outer = ~pass_q;
    cmd_o.vertex_number = {k_q, pass_q};
    cmd_o.path_start = (k_q == 5'd0) && !pass_q;
    cmd_o.path_end = last_vtx;
  end

  `SVG_ASSERT(a_ready_idle, clk_i, rst_ni, in_ready_o |-> !cmd_valid_o)
  `SVG_ASSERT(a_sides_ok, clk_i, rst_ni,
    cmd_valid_o |-> (sides_q >= 6'd3 && sides_q <= 6'd32))
  `SVG_ASSERT(a_end_idle, clk_i, rst_ni,
    (cmd_valid_o && cmd_ready_i && cmd_o.path_end) |=> in_ready_o)
endmodule

// ----- hdl/svg_back.sv -----
// ---------------------------------------------------------------------------
// svg_back: cordic vertex engine
// one job at a time: quadrant fold, 24 cordic steps, scale by radius,
// round, offset and saturate, then an output register
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module svg_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  svg_pkg::vtx_cmd_t cmd_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [25:0]       point_x_o,
  output logic [25:0]       point_y_o,
  output logic              is_outer_o,
  output logic [5:0]        vertex_number_o,
  output logic              path_start_o,
  output logic              path_end_o
);
  import svg_pkg::*;

  bk_state_e          state_q, state_d;
  vtx_cmd_t           job_q;
  logic [1:0]         quad_q;
  logic signed [33:0] x_q, y_q;
  logic signed [33:0] z_q;
  logic [4:0]         it_q;
  logic signed [58:0] px_q, py_q;
  logic               ov_q, ov_d;
  logic [25:0]        ox_q, oy_q;

  logic [31:0]        a32;
  logic [1:0]         qd;
  logic [31:0]        rres;
  logic signed [33:0] xs, ys, at;
  logic signed [33:0] cs, sn;
  logic signed [58:0] rx, ry;
  logic signed [26:0] vx, vy;

  assign a32 = {cmd_i.angle, 16'd0};
  assign qd = 2'(((a32 + 32'h20000000) >> 30));
  assign rres = a32 - {qd, 30'd0};
  assign xs = x_q >>> it_q;
  assign ys = y_q >>> it_q;
  assign at = {2'b00, atan_turn(it_q)};

  // quadrant rotation of the cordic result
  always_comb begin
    case (quad_q)
      2'd0: begin cs = x_q;  sn = y_q;  end
      2'd1: begin cs = -y_q; sn = x_q;  end
      2'd2: begin cs = -x_q; sn = -y_q; end
      default: begin cs = y_q; sn = -x_q; end
    endcase
  end

  // rounded offset plus center, saturated
  function automatic logic [25:0] sat26(input logic signed [26:0] v);
    if (v > 27'sd33554431) return 26'h1FFFFFF;
    if (v < -27'sd33554432) return 26'h2000000;
    return v[25:0];
  endfunction

  assign rx = (px_q + 59'sd536870912) >>> 30;
  assign ry = (py_q + 59'sd536870912) >>> 30;
  assign vx = 27'(signed'(job_q.center_x)) + 27'(rx);
  assign vy = 27'(signed'(job_q.center_y)) + 27'(ry);

  assign cmd_ready_o = (state_q == BkIdle);
  assign out_valid_o = ov_q;

  // next phase and output valid
  always_comb begin
    state_d = state_q;
    ov_d = ov_q;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    unique case (state_q)
      BkIdle:   if (cmd_valid_i) state_d = BkCordic;
      BkCordic: if (it_q == 5'(CordicIters - 1)) state_d = BkMul;
      BkMul:    state_d = BkPlace;
      BkPlace:  state_d = BkOut;
      BkOut: begin
        if (!ov_q || out_ready_i) begin
          ov_d = 1'b1;
          state_d = BkIdle;
        end
      end
      default: state_d = BkIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BkIdle;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      BkIdle: begin
        job_q <= cmd_i;
        quad_q <= qd;
        x_q <= 34'sd652032874;
        y_q <= 34'sd0;
        z_q <= 34'(signed'(rres));
        it_q <= 5'd0;
      end
      BkCordic: begin
        if (!z_q[33]) begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - at;
        end else begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + at;
        end
        it_q <= it_q + 5'd1;
      end
      BkMul: begin
        px_q <= 59'(signed'({1'b0, job_q.radius})) * 59'(cs);
        py_q <= 59'(signed'({1'b0, job_q.radius})) * 59'(sn);
      end
      BkPlace: begin
        ox_q <= sat26(vx);
        oy_q <= sat26(vy);
      end
      BkOut: begin
        if (!ov_q || out_ready_i) begin
          point_x_o <= ox_q;
          point_y_o <= oy_q;
          is_outer_o <= job_q.is_outer;
          vertex_number_o <= job_q.vertex_number;
          path_start_o <= job_q.path_start;
          path_end_o <= job_q.path_end;
        end
      end
      default: ;
    endcase
  end

  `SVG_ASSERT(a_iter_range, clk_i, rst_ni,
    (state_q == BkCordic) |-> (it_q < 5'(CordicIters)))
  `SVG_ASSERT(a_accept_idle, clk_i, rst_ni,
    (cmd_valid_i && cmd_ready_o) |=> (state_q == BkCordic))
  `SVG_ASSERT(a_hold_out, clk_i, rst_ni,
    (out_valid_o && !out_ready_i) |=> out_valid_o)
endmodule

// ----- hdl/svg_queue.sv -----
// ---------------------------------------------------------------------------
// svg_queue: two-entry job queue between front and back
// decouples vertex sequencing from the cordic engine
// ---------------------------------------------------------------------------
module svg_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_valid_i,
  output logic              wr_ready_o,
  input  svg_pkg::vtx_cmd_t wr_data_i,
  output logic              rd_valid_o,
  input  logic              rd_ready_i,
  output svg_pkg::vtx_cmd_t rd_data_o
);
  import svg_pkg::*;

  vtx_cmd_t   mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign rd_data_o = mem_q[rp_q];
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end
endmodule
